// ----- hw/rtl/owbm_pkg.sv -----
// Package for the 1-Wire bus master: operation, phase and register codes,
// transaction and configuration types, and the slot timing helper functions.
// Has no dependencies; every other file of the block imports it.
package owbm_pkg;

  localparam int unsigned CNT_W = 12;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned BIT_CNT_W = 4;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;

  localparam int unsigned READ_SAMPLE_TICKS = 1;
  localparam int unsigned RESET_LEAD_TICKS = 1;

  localparam logic [ACTION_W-1:0] OP_IDLE  = 3'd0;
  localparam logic [ACTION_W-1:0] OP_RESET = 3'd1;
  localparam logic [ACTION_W-1:0] OP_WRITE = 3'd2;
  localparam logic [ACTION_W-1:0] OP_READ  = 3'd3;
  localparam logic [ACTION_W-1:0] OP_TOUCH = 3'd4;

  localparam logic [1:0] KIND_RESET = 2'd0;
  localparam logic [1:0] KIND_W1    = 2'd1;
  localparam logic [1:0] KIND_W0    = 2'd2;
  localparam logic [1:0] KIND_RD    = 2'd3;

  localparam logic [1:0] PH_LEAD  = 2'd0;
  localparam logic [1:0] PH_LOW   = 2'd1;
  localparam logic [1:0] PH_WAIT  = 2'd2;
  localparam logic [1:0] PH_RECOV = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_W1_RECOV   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_W0_LOW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_W0_RECOV   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RD_RECOV   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RST_LOW    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PRES_WAIT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RST_RECOV  = 3'd7;

  typedef struct packed {
    logic [CNT_W-1:0] short_low;
    logic [CNT_W-1:0] w1_recov;
    logic [CNT_W-1:0] w0_low;
    logic [CNT_W-1:0] w0_recov;
    logic [CNT_W-1:0] rd_recov;
    logic [CNT_W-1:0] rst_low;
    logic [CNT_W-1:0] pres_wait;
    logic [CNT_W-1:0] rst_recov;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    short_low: 12'd3,
    w1_recov:  12'd360,
    w0_low:    12'd300,
    w0_recov:  12'd63,
    rd_recov:  12'd360,
    rst_low:   12'd1455,
    pres_wait: 12'd180,
    rst_recov: 12'd750
  };

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   tx_byte;
    logic                bus_level;
  } cmd_t;

  typedef struct packed {
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              no_presence;
    logic              command_rejected;
  } res_t;

  typedef struct packed {
    logic             stop;
    logic [1:0]       ph;
    logic [CNT_W-1:0] len;
    logic             pass_wait;
  } seek_t;

  function automatic logic [1:0] slot_kind(logic [ACTION_W-1:0] op, logic bit0);
    logic [1:0] k;
    case (op)
      OP_RESET: k = KIND_RESET;
      OP_WRITE: k = bit0 ? KIND_W1 : KIND_W0;
      OP_READ:  k = KIND_RD;
      default:  k = bit0 ? KIND_RD : KIND_W0;
    endcase
    return k;
  endfunction

  function automatic logic [CNT_W-1:0] phase_len(cfg_t c, logic [1:0] kind, logic [1:0] ph);
    logic [CNT_W-1:0] v;
    case (kind)
      KIND_RESET: begin
        case (ph)
          PH_LEAD: v = CNT_W'(RESET_LEAD_TICKS);
          PH_LOW:  v = c.rst_low;
          PH_WAIT: v = c.pres_wait;
          default: v = c.rst_recov;
        endcase
      end
      KIND_W1: v = (ph == PH_LOW) ? c.short_low : c.w1_recov;
      KIND_W0: v = (ph == PH_LOW) ? c.w0_low : c.w0_recov;
      default: begin
        case (ph)
          PH_LOW:  v = c.short_low;
          PH_WAIT: v = CNT_W'(READ_SAMPLE_TICKS);
          default: v = c.rd_recov;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic kind_any(cfg_t c, logic [1:0] kind);
    logic a;
    case (kind)
      KIND_W1: a = (c.short_low != '0) || (c.w1_recov != '0);
      KIND_W0: a = (c.w0_low != '0) || (c.w0_recov != '0);
      KIND_RD: a = (c.short_low != '0) || (READ_SAMPLE_TICKS != 0) || (c.rd_recov != '0);
      default: a = 1'b1;
    endcase
    return a;
  endfunction

  // Finds the first phase of nonzero length at or after ps within one slot.
  function automatic seek_t seek_phase(cfg_t c, logic [1:0] kind, logic [1:0] ps);
    logic [CNT_W-1:0] l_low;
    logic [CNT_W-1:0] l_wait;
    logic [CNT_W-1:0] l_rec;
    logic             has_wait;
    seek_t            s;
    l_low    = phase_len(c, kind, PH_LOW);
    l_wait   = phase_len(c, kind, PH_WAIT);
    l_rec    = phase_len(c, kind, PH_RECOV);
    has_wait = (kind == KIND_RESET) || (kind == KIND_RD);
    s = '0;
    if (ps <= PH_LOW && l_low != '0) begin
      s.stop = 1'b1;
      s.ph   = PH_LOW;
      s.len  = l_low;
    end else if (has_wait && ps <= PH_WAIT && l_wait != '0) begin
      s.stop = 1'b1;
      s.ph   = PH_WAIT;
      s.len  = l_wait;
    end else begin
      s.pass_wait = has_wait && (ps <= PH_WAIT);
      if (l_rec != '0) begin
        s.stop = 1'b1;
        s.ph   = PH_RECOV;
        s.len  = l_rec;
      end
    end
    return s;
  endfunction

endpackage

// ----- hw/rtl/owbm_ifs.sv -----
// Handshake channel interfaces of the 1-Wire bus master: command and result.
// Depends on owbm_pkg for the payload widths.
interface owbm_cmd_if import owbm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [BYTE_W-1:0]   tx_byte;
  logic                bus_level;

  modport source(output valid, action, tx_byte, bus_level, input ready);
  modport sink(input valid, action, tx_byte, bus_level, output ready);
endinterface

interface owbm_res_if import owbm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              drive_low;
  logic              busy_res;
  logic              done_res;
  logic [BYTE_W-1:0] rx_byte;
  logic              no_presence;
  logic              command_rejected;

  modport source(output valid, drive_low, busy_res, done_res, rx_byte, no_presence,
                 command_rejected, input ready);
  modport sink(input valid, drive_low, busy_res, done_res, rx_byte, no_presence,
               command_rejected, output ready);
endinterface

// ----- hw/rtl/owbm_regs.sv -----
// APB configuration registers of the 1-Wire bus master: slot tick counts.
// Depends on owbm_pkg for cfg_t, the register indexes and the reset values.
module owbm_regs import owbm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic                 wr_en;
  logic [CFG_IDX_W-1:0] idx;
  logic [CNT_W-1:0]     wval;
  logic [CNT_W-1:0]     rval;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[APB_ADDR_W-1:2];
  assign wval   = pwdata[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_SHORT_LOW: cfg.short_low <= wval;
        REG_W1_RECOV:  cfg.w1_recov  <= wval;
        REG_W0_LOW:    cfg.w0_low    <= wval;
        REG_W0_RECOV:  cfg.w0_recov  <= wval;
        REG_RD_RECOV:  cfg.rd_recov  <= wval;
        REG_RST_LOW:   cfg.rst_low   <= wval;
        REG_PRES_WAIT: cfg.pres_wait <= wval;
        REG_RST_RECOV: cfg.rst_recov <= wval;
        default:       cfg <= cfg;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SHORT_LOW: rval = cfg.short_low;
      REG_W1_RECOV:  rval = cfg.w1_recov;
      REG_W0_LOW:    rval = cfg.w0_low;
      REG_W0_RECOV:  rval = cfg.w0_recov;
      REG_RD_RECOV:  rval = cfg.rd_recov;
      REG_RST_LOW:   rval = cfg.rst_low;
      REG_PRES_WAIT: rval = cfg.pres_wait;
      REG_RST_RECOV: rval = cfg.rst_recov;
      default:       rval = '0;
    endcase
  end

  assign prdata = {{(APB_DATA_W-CNT_W){1'b0}}, rval};

endmodule

// ----- hw/rtl/owbm_seq.sv -----
// Slot sequencer of the 1-Wire bus master: operation state and the one-tick
// step logic that skips phases of zero length. Depends on owbm_pkg.
module owbm_seq import owbm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  cmd_t cmd_item,
  input  cfg_t cfg,
  output res_t res_next
);

  logic [ACTION_W-1:0]  op, op_next;
  logic [1:0]           phase, phase_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [BIT_CNT_W-1:0] bc, bc_next;
  logic [BYTE_W-1:0]    so, so_next;
  logic [BYTE_W-1:0]    si, si_next;
  logic                 pres, pres_next;

  always_comb begin : step
    logic [1:0]             kind;
    logic [1:0]             ps;
    logic [1:0]             kj;
    logic                   fin;
    logic                   found;
    logic                   rejected;
    logic                   drive;
    logic                   bus;
    seek_t                  sk;
    logic [BIT_CNT_W-1:0]   rem;
    logic [BIT_CNT_W-1:0]   m;
    logic [BYTE_W-1:0]      vbits;
    logic [BYTE_W-1:0]      bit_any;
    logic [2*BYTE_W-1:0]    cat;

    op_next    = op;
    phase_next = phase;
    cnt_next   = cnt;
    bc_next    = bc;
    so_next    = so;
    si_next    = si;
    pres_next  = pres;
    kind       = KIND_RESET;
    ps         = PH_LOW;
    kj         = KIND_RESET;
    fin        = 1'b0;
    found      = 1'b0;
    rejected   = 1'b0;
    drive      = 1'b0;
    bus        = cmd_item.bus_level;
    sk         = '0;
    rem        = '0;
    m          = '0;
    vbits      = '0;
    bit_any    = '0;
    cat        = '0;

    if (fire) begin
      if (op != OP_IDLE) begin
        rejected = cmd_item.action inside {OP_RESET, OP_WRITE, OP_READ, OP_TOUCH};
      end else if (cmd_item.action inside {OP_RESET, OP_WRITE, OP_READ, OP_TOUCH}) begin
        op_next = cmd_item.action;
        bc_next = '0;
        so_next = cmd_item.tx_byte;
        if (cmd_item.action == OP_READ || cmd_item.action == OP_TOUCH) begin
          si_next = '0;
        end
        phase_next = (cmd_item.action == OP_RESET) ? PH_LEAD : PH_LOW;
        cnt_next = phase_len(cfg, slot_kind(cmd_item.action, cmd_item.tx_byte[0]), phase_next);
      end

      if (op_next != OP_IDLE && cnt_next == '0) begin
        kind = slot_kind(op_next, so_next[0]);
        case (phase_next)
          PH_LEAD: ps = PH_LOW;
          PH_LOW: begin
            ps = (kind == KIND_RESET || kind == KIND_RD) ? PH_WAIT : PH_RECOV;
          end
          PH_WAIT: begin
            if (kind == KIND_RESET) begin
              pres_next = bus;
            end else begin
              si_next = {bus, si_next[BYTE_W-1:1]};
            end
            ps = PH_RECOV;
          end
          default: begin
            if (kind == KIND_RESET) begin
              fin = 1'b1;
            end else begin
              if (op_next == OP_TOUCH && kind == KIND_W0) begin
                si_next = si_next >> 1;
              end
              so_next = so_next >> 1;
              bc_next = bc_next + 1'b1;
              fin = (bc_next == BITS_PER_BYTE);
              ps = PH_LOW;
            end
          end
        endcase

        if (!fin) begin
          kind = slot_kind(op_next, so_next[0]);
          sk = seek_phase(cfg, kind, ps);
          if (sk.pass_wait) begin
            if (kind == KIND_RESET) begin
              pres_next = bus;
            end else begin
              si_next = {bus, si_next[BYTE_W-1:1]};
            end
          end
          if (sk.stop) begin
            phase_next = sk.ph;
            cnt_next = sk.len;
          end else if (kind == KIND_RESET) begin
            fin = 1'b1;
          end else begin
            if (op_next == OP_TOUCH && kind == KIND_W0) begin
              si_next = si_next >> 1;
            end
            so_next = so_next >> 1;
            bc_next = bc_next + 1'b1;
            if (bc_next == BITS_PER_BYTE) begin
              fin = 1'b1;
            end else begin
              // Whole bit slots of zero length are skipped together.
              rem = BITS_PER_BYTE - bc_next;
              for (int j = 0; j < BYTE_W; j++) begin
                kj = slot_kind(op_next, so_next[j]);
                bit_any[j] = (BIT_CNT_W'(j) < rem) && kind_any(cfg, kj);
                vbits[j] = (kj == KIND_RD) && bus;
              end
              m = rem;
              for (int j = BYTE_W - 1; j >= 0; j--) begin
                if (bit_any[j]) begin
                  found = 1'b1;
                  m = BIT_CNT_W'(j);
                end
              end
              cat = {vbits, si_next} >> m;
              if (op_next != OP_WRITE) begin
                si_next = cat[BYTE_W-1:0];
              end
              so_next = so_next >> m;
              bc_next = bc_next + m;
              if (!found) begin
                fin = 1'b1;
              end else begin
                kind = slot_kind(op_next, so_next[0]);
                sk = seek_phase(cfg, kind, PH_LOW);
                if (sk.pass_wait) begin
                  si_next = {bus, si_next[BYTE_W-1:1]};
                end
                phase_next = sk.ph;
                cnt_next = sk.len;
              end
            end
          end
        end
      end

      if (fin) begin
        op_next = OP_IDLE;
        phase_next = PH_LEAD;
        cnt_next = '0;
      end else if (op_next != OP_IDLE) begin
        drive = (phase_next == PH_LOW);
        cnt_next = cnt_next - 1'b1;
      end
    end

    res_next.drive_low        = drive;
    res_next.busy_res         = (op_next != OP_IDLE);
    res_next.done_res         = fin;
    res_next.rx_byte          = si_next;
    res_next.no_presence      = pres_next;
    res_next.command_rejected = rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op    <= OP_IDLE;
      phase <= PH_LEAD;
      cnt   <= '0;
      bc    <= '0;
      so    <= '0;
      si    <= '0;
      pres  <= 1'b0;
    end else begin
      op    <= op_next;
      phase <= phase_next;
      cnt   <= cnt_next;
      bc    <= bc_next;
      so    <= so_next;
      si    <= si_next;
      pres  <= pres_next;
    end
  end

`ifndef SYNTHESIS
  a_reject_only_busy: assert property (@(posedge clk) disable iff (rst)
    fire && res_next.command_rejected |-> op != OP_IDLE)
    else $error("command rejected while the sequencer was idle");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    op == OP_IDLE |-> cnt == '0)
    else $error("tick counter left running while idle");

  a_bits_in_range: assert property (@(posedge clk) disable iff (rst)
    op != OP_IDLE && op != OP_RESET |-> bc < BITS_PER_BYTE)
    else $error("bit count ran past the byte during an operation");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    fire && res_next.done_res |=> op == OP_IDLE)
    else $error("operation still active after done");

  a_drive_in_low: assert property (@(posedge clk) disable iff (rst)
    fire && res_next.drive_low |=> phase == PH_LOW)
    else $error("line driven low outside a low phase");
`endif

endmodule

// ----- hw/rtl/onewire_bus_master.sv -----
// 1-Wire bus master top level: command input register, slot sequencer,
// result output register and APB configuration registers.
// A taken command is registered and stepped by the single-pass step logic once the
// result register is free. Throughput: one tick transaction per cycle while results flow.
// Reset (rst, synchronous): control registers return to their defaults, the bus is idle.
// Depends on owbm_pkg, owbm_ifs, owbm_regs and owbm_seq.
module onewire_bus_master import owbm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  owbm_cmd_if.sink              cmd,
  owbm_res_if.source            res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;
  cmd_t cmd_q;
  logic cmd_valid;
  res_t res_n;
  res_t res_q;
  logic res_valid;
  logic fire;

  assign fire      = cmd_valid && (!res_valid || res.ready);
  assign cmd.ready = !cmd_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      cmd_valid <= 1'b1;
    end else if (fire) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      cmd_q <= '{action: cmd.action, tx_byte: cmd.tx_byte, bus_level: cmd.bus_level};
    end
  end

  owbm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  owbm_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .cmd_item (cmd_q),
    .cfg      (cfg),
    .res_next (res_n)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res_n;
    end
  end

  assign res.valid            = res_valid;
  assign res.drive_low        = res_q.drive_low;
  assign res.busy_res         = res_q.busy_res;
  assign res.done_res         = res_q.done_res;
  assign res.rx_byte          = res_q.rx_byte;
  assign res.no_presence      = res_q.no_presence;
  assign res.command_rejected = res_q.command_rejected;

endmodule

// ----- bench/tb_onewire_bus_master.sv -----
`timescale 1ns / 100ps
// Testbench for the 1-Wire bus master: drives tick transactions, predicts every
// result cycle by cycle and programs the slot timing over APB between phases.
// Depends on owbm_pkg, owbm_ifs and the onewire_bus_master RTL.
module tb_onewire_bus_master import owbm_pkg::*; ();

  localparam logic [ACTION_W-1:0] ACT_UNDEF_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_UNDEF_HI = 3'd7;
  localparam int LEVEL_RANDOM = 2;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 400;
  localparam int PRINT_LIMIT = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  owbm_cmd_if cmd_ch ();
  owbm_res_if res_ch ();

  onewire_bus_master dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted state of the bus master.
  cfg_t timing;
  logic [ACTION_W-1:0] bus_op;
  logic [1:0] bus_phase;
  logic [CNT_W-1:0] tick_left;
  logic [BIT_CNT_W-1:0] bits_done;
  logic [BYTE_W-1:0] tx_shift;
  logic [BYTE_W-1:0] rx_shift;
  logic no_dev_seen;

  cmd_t tick_queue[$];
  res_t line_results[$];
  cmd_t taken;
  cmd_t offer;
  res_t want_res;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int errors = 0;

  function automatic logic [1:0] slot_type();
    logic [1:0] k;
    case (bus_op)
      OP_RESET: k = KIND_RESET;
      OP_WRITE: k = tx_shift[0] ? KIND_W1 : KIND_W0;
      OP_READ:  k = KIND_RD;
      default:  k = tx_shift[0] ? KIND_RD : KIND_W0;
    endcase
    return k;
  endfunction

  function automatic logic [CNT_W-1:0] slot_ticks(logic [1:0] kind, logic [1:0] ph);
    logic [CNT_W-1:0] v;
    if (kind == KIND_RESET) begin
      case (ph)
        PH_LEAD: v = CNT_W'(RESET_LEAD_TICKS);
        PH_LOW:  v = timing.rst_low;
        PH_WAIT: v = timing.pres_wait;
        default: v = timing.rst_recov;
      endcase
    end else if (kind == KIND_W1) begin
      v = (ph == PH_LOW) ? timing.short_low : timing.w1_recov;
    end else if (kind == KIND_W0) begin
      v = (ph == PH_LOW) ? timing.w0_low : timing.w0_recov;
    end else begin
      case (ph)
        PH_LOW:  v = timing.short_low;
        PH_WAIT: v = CNT_W'(READ_SAMPLE_TICKS);
        default: v = timing.rd_recov;
      endcase
    end
    return v;
  endfunction

  function automatic void open_phase(logic [1:0] ph);
    bus_phase = ph;
    tick_left = slot_ticks(slot_type(), ph);
  endfunction

  // Closes the current phase and returns 1 when the whole operation is over.
  function automatic bit close_phase(logic bus);
    logic [1:0] kind;
    kind = slot_type();
    if (bus_phase == PH_LEAD) begin
      open_phase(PH_LOW);
      return 1'b0;
    end
    if (bus_phase == PH_LOW) begin
      open_phase((kind == KIND_W1 || kind == KIND_W0) ? PH_RECOV : PH_WAIT);
      return 1'b0;
    end
    if (bus_phase == PH_WAIT) begin
      if (kind == KIND_RESET) no_dev_seen = bus;
      else rx_shift = {bus, rx_shift[BYTE_W-1:1]};
      open_phase(PH_RECOV);
      return 1'b0;
    end
    if (kind == KIND_RESET) return 1'b1;
    if (bus_op == OP_TOUCH && kind == KIND_W0) rx_shift = rx_shift >> 1;
    tx_shift = tx_shift >> 1;
    bits_done = bits_done + 1'b1;
    if (bits_done >= BITS_PER_BYTE) return 1'b1;
    open_phase(PH_LOW);
    return 1'b0;
  endfunction

  function automatic res_t master_tick(cmd_t c);
    res_t r;
    bit fin;
    int guard;
    r = '0;
    fin = 1'b0;
    if (bus_op != OP_IDLE) begin
      if (c.action >= OP_RESET && c.action <= OP_TOUCH) r.command_rejected = 1'b1;
    end else if (c.action >= OP_RESET && c.action <= OP_TOUCH) begin
      bus_op = c.action;
      bits_done = '0;
      tx_shift = c.tx_byte;
      if (c.action == OP_READ || c.action == OP_TOUCH) rx_shift = '0;
      open_phase((c.action == OP_RESET) ? PH_LEAD : PH_LOW);
    end
    if (bus_op != OP_IDLE) begin
      for (guard = 0; guard < 64 && tick_left == '0 && !fin; guard++)
        fin = close_phase(c.bus_level);
      if (fin) begin
        bus_op = OP_IDLE;
        bus_phase = PH_LEAD;
        tick_left = '0;
        r.done_res = 1'b1;
      end else if (tick_left != '0) begin
        r.drive_low = (bus_phase == PH_LOW);
        tick_left = tick_left - 1'b1;
      end
    end
    r.busy_res = (bus_op != OP_IDLE);
    r.rx_byte = rx_shift;
    r.no_presence = no_dev_seen;
    return r;
  endfunction

  task automatic report_failure(string msg);
    errors++;
    if (errors <= PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_failure($sformatf("%s is %0h, predicted %0h", name, got, want));
  endtask

  // Tick driver: the predictor runs on every accepted transaction.
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        taken.action = cmd_ch.action;
        taken.tx_byte = cmd_ch.tx_byte;
        taken.bus_level = cmd_ch.bus_level;
        line_results.push_back(master_tick(taken));
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (tick_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          offer = tick_queue.pop_front();
          cmd_ch.valid <= 1'b1;
          cmd_ch.action <= offer.action;
          cmd_ch.tx_byte <= offer.tx_byte;
          cmd_ch.bus_level <= offer.bus_level;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= LONG_HOLD;
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (line_results.size() == 0) begin
        report_failure("result transaction with no tick waiting for it");
      end else begin
        want_res = line_results.pop_front();
        check_field("drive_low", res_ch.drive_low, want_res.drive_low);
        check_field("busy_res", res_ch.busy_res, want_res.busy_res);
        check_field("done_res", res_ch.done_res, want_res.done_res);
        check_field("rx_byte", res_ch.rx_byte, want_res.rx_byte);
        check_field("no_presence", res_ch.no_presence, want_res.no_presence);
        check_field("command_rejected", res_ch.command_rejected,
                    want_res.command_rejected);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_tick(logic [ACTION_W-1:0] act, logic [BYTE_W-1:0] b, int lvl);
    cmd_t c;
    c.action = act;
    c.tx_byte = b;
    c.bus_level = (lvl == LEVEL_RANDOM) ? 1'($urandom) : 1'(lvl);
    tick_queue.push_back(c);
  endtask

  // Feeds empty ticks until the operation is over and every result is back.
  task automatic settle(int lvl);
    bit quiet;
    quiet = 1'b0;
    while (!quiet) begin
      @(negedge clk);
      if (tick_queue.size() == 0 && !cmd_ch.valid) begin
        if (bus_op != OP_IDLE) repeat (32) push_tick(OP_IDLE, 8'($urandom), lvl);
        else if (line_results.size() == 0) quiet = 1'b1;
      end
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic run_cmd(logic [ACTION_W-1:0] act, logic [BYTE_W-1:0] b, int lvl);
    push_tick(act, b, lvl);
    settle(lvl);
  endtask

  task automatic apb_write(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {20'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_check(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] want);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {{(APB_DATA_W-CNT_W){1'b0}}, want})
      report_failure($sformatf("register %0d reads %0h, expected %0h", idx, prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_timing(cfg_t c);
    apb_write(REG_SHORT_LOW, c.short_low);
    apb_write(REG_W1_RECOV, c.w1_recov);
    apb_write(REG_W0_LOW, c.w0_low);
    apb_write(REG_W0_RECOV, c.w0_recov);
    apb_write(REG_RD_RECOV, c.rd_recov);
    apb_write(REG_RST_LOW, c.rst_low);
    apb_write(REG_PRES_WAIT, c.pres_wait);
    apb_write(REG_RST_RECOV, c.rst_recov);
    timing = c;
  endtask

  function automatic cfg_t random_timing(int top);
    cfg_t c;
    c.short_low = CNT_W'($urandom_range(top));
    c.w1_recov = CNT_W'($urandom_range(top));
    c.w0_low = CNT_W'($urandom_range(top));
    c.w0_recov = CNT_W'($urandom_range(top));
    c.rd_recov = CNT_W'($urandom_range(top));
    c.rst_low = CNT_W'($urandom_range(top));
    c.pres_wait = CNT_W'($urandom_range(top));
    c.rst_recov = CNT_W'($urandom_range(top));
    return c;
  endfunction

  // Mostly commands issued while idle followed by their ticks, plus commands
  // thrown in while busy and undefined actions.
  task automatic run_random(int n_ticks, bit with_hold);
    int sent;
    int r;
    int k;
    bit held;
    sent = 0;
    held = 1'b0;
    while (sent < n_ticks) begin
      @(negedge clk);
      if (with_hold && !held && sent >= 50) begin
        hold_req++;
        held = 1'b1;
      end
      if (tick_queue.size() < 2) begin
        r = $urandom_range(99);
        k = 1;
        if (bus_op == OP_IDLE) begin
          if (r < 75) begin
            push_tick(ACTION_W'($urandom_range(OP_TOUCH, OP_RESET)), 8'($urandom),
                      LEVEL_RANDOM);
          end else if (r < 85) begin
            push_tick(ACTION_W'($urandom_range(ACT_UNDEF_HI, ACT_UNDEF_LO)), 8'($urandom),
                      LEVEL_RANDOM);
          end else begin
            k = $urandom_range(3, 1);
            repeat (k) push_tick(OP_IDLE, 8'($urandom), LEVEL_RANDOM);
          end
        end else if (r < 8) begin
          push_tick(ACTION_W'($urandom), 8'($urandom), LEVEL_RANDOM);
        end else begin
          k = $urandom_range(8, 1);
          repeat (k) push_tick(OP_IDLE, 8'($urandom), LEVEL_RANDOM);
        end
        sent += k;
      end
    end
    settle(LEVEL_RANDOM);
  endtask

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.action = OP_IDLE;
    cmd_ch.tx_byte = '0;
    cmd_ch.bus_level = 1'b0;
    res_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    timing = CFG_RESET;
    bus_op = OP_IDLE;
    bus_phase = PH_LEAD;
    tick_left = '0;
    bits_done = '0;
    tx_shift = '0;
    rx_shift = '0;
    no_dev_seen = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Timing registers after reset.
    apb_check(REG_SHORT_LOW, CFG_RESET.short_low);
    apb_check(REG_W1_RECOV, CFG_RESET.w1_recov);
    apb_check(REG_W0_LOW, CFG_RESET.w0_low);
    apb_check(REG_W0_RECOV, CFG_RESET.w0_recov);
    apb_check(REG_RD_RECOV, CFG_RESET.rd_recov);
    apb_check(REG_RST_LOW, CFG_RESET.rst_low);
    apb_check(REG_PRES_WAIT, CFG_RESET.pres_wait);
    apb_check(REG_RST_RECOV, CFG_RESET.rst_recov);

    load_timing('{short_low: 12'd2, w1_recov: 12'd3, w0_low: 12'd4, w0_recov: 12'd1,
                  rd_recov: 12'd2, rst_low: 12'd5, pres_wait: 12'd2, rst_recov: 12'd3});
    run_cmd(OP_RESET, 8'h00, 0);
    run_cmd(OP_RESET, 8'hFF, 1);
    run_cmd(OP_WRITE, 8'h00, LEVEL_RANDOM);
    run_cmd(OP_WRITE, 8'hFF, LEVEL_RANDOM);
    run_cmd(OP_WRITE, 8'hA5, LEVEL_RANDOM);
    run_cmd(OP_READ, 8'h00, 1);
    run_cmd(OP_READ, 8'hFF, 0);
    run_cmd(OP_READ, 8'h3C, LEVEL_RANDOM);
    run_cmd(OP_TOUCH, 8'hFF, 1);
    run_cmd(OP_TOUCH, 8'h00, 1);
    run_cmd(OP_TOUCH, 8'h5A, LEVEL_RANDOM);

    // Commands and undefined actions arriving while a write is running.
    push_tick(OP_WRITE, 8'h3C, LEVEL_RANDOM);
    push_tick(OP_READ, 8'hFF, LEVEL_RANDOM);
    push_tick(OP_RESET, 8'h00, LEVEL_RANDOM);
    push_tick(OP_TOUCH, 8'hAA, LEVEL_RANDOM);
    for (int a = ACT_UNDEF_LO; a <= ACT_UNDEF_HI; a++)
      push_tick(ACTION_W'(a), 8'h55, LEVEL_RANDOM);
    settle(LEVEL_RANDOM);
    push_tick(ACT_UNDEF_HI, 8'hFF, LEVEL_RANDOM);
    run_cmd(OP_IDLE, 8'hFF, LEVEL_RANDOM);

    // Every configurable phase of zero length.
    load_timing('0);
    run_cmd(OP_WRITE, 8'hFF, LEVEL_RANDOM);
    run_cmd(OP_WRITE, 8'h00, LEVEL_RANDOM);
    run_cmd(OP_READ, 8'h00, 1);
    run_cmd(OP_TOUCH, 8'hA5, LEVEL_RANDOM);
    run_cmd(OP_RESET, 8'h00, 1);

    load_timing(random_timing(3));
    run_random(110, 1'b1);

    send_gap_pct = 46;
    load_timing(random_timing(5));
    run_random(110, 1'b0);

    send_gap_pct = 0;
    stall_pct = 46;
    load_timing(random_timing(3));
    run_random(110, 1'b0);

    send_gap_pct = 14;
    stall_pct = 14;
    load_timing(random_timing(6));
    run_random(110, 1'b0);

    repeat (8) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/owbm_pkg.sv
hw/rtl/owbm_ifs.sv
hw/rtl/owbm_regs.sv
hw/rtl/owbm_seq.sv
hw/rtl/onewire_bus_master.sv
bench/tb_onewire_bus_master.sv
